// ===== rtl/srt_pkg.sv =====
// Shared types and constants for the slot range table.
package srt_pkg;

   localparam int SLOT_W  = 14;
   localparam int SHARD_W = 6;
   localparam int COUNT_W = 7;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_NONE   = 2'd3
   } srt_op_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  first_slot;
      logic [SLOT_W-1:0]  last_slot;
      logic [SHARD_W-1:0] shard;
   } srt_range_type;

   // Command broadcast to every cell for the item in flight.
   typedef struct packed {
      logic              clear;
      logic              insert;
      logic              any_eq;
      logic              room;
      srt_range_type     key;
      logic [SLOT_W-1:0] query;
   } srt_cmd_type;

   // Per-cell compare and status results.
   typedef struct packed {
      logic lt;
      logic eq;
      logic le;
      logic hit;
      logic link_ok;
      logic tail_ok;
      logic overlap;
   } srt_flags_type;

endpackage

// ===== rtl/srt_if.sv =====
// Valid/ready channel interfaces for requests and responses.
interface srt_req_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 op;
   logic [srt_pkg::SLOT_W-1:0]  range_start;
   logic [srt_pkg::SLOT_W-1:0]  range_end;
   logic [srt_pkg::SHARD_W-1:0] shard_index;
   logic [srt_pkg::SLOT_W-1:0]  query_slot;

   modport source (output valid, op, range_start, range_end, shard_index, query_slot,
                   input ready);
   modport sink (input valid, op, range_start, range_end, shard_index, query_slot,
                 output ready);
endinterface

interface srt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic [srt_pkg::SHARD_W-1:0] found_shard;
   logic                        covers_all;
   logic                        overlap_seen;
   logic                        insert_dropped;
   logic [srt_pkg::COUNT_W-1:0] entry_count;

   modport source (output valid, hit, found_shard, covers_all, overlap_seen,
                   insert_dropped, entry_count, input ready);
   modport sink (input valid, hit, found_shard, covers_all, overlap_seen,
                 insert_dropped, entry_count, output ready);
endinterface

// ===== rtl/slot_range_table_lookup.sv =====
// Slot range table: sorted chain of range cells with clear, lookup, insert and status.
//
//  channel | dir | payload
//  req_bus | in  | op, range_start, range_end, shard_index, query_slot
//  rsp_bus | out | hit, found_shard, covers_all, overlap_seen, insert_dropped, entry_count
//
// An item moves from the pending registers into the response register: the cell chain compares
// and updates in the accept cycle, and once the response register is free the chain status
// (coverage, overlap) is gathered into it, which raises rsp_bus.valid.
// Reset empties the table at once; a new item is taken while a response waits,
// and a further one stalls until the response register frees up.
module slot_range_table_lookup #(
   parameter int NUM_SLOTS  = 16384,
   parameter int MAX_RANGES = 64,
   parameter int MAX_SHARDS = 64
) (
   input logic       clock,
   input logic       reset,
   srt_req_if.sink   req_bus,
   srt_rsp_if.source rsp_bus
);

   localparam int CNT_W = $clog2(MAX_RANGES + 1);

   srt_pkg::srt_cmd_type   cmd;
   srt_pkg::srt_range_type ranges [MAX_RANGES];
   srt_pkg::srt_flags_type flags  [MAX_RANGES];
   logic [srt_pkg::SLOT_W:0] end_plus [MAX_RANGES];
   logic [MAX_RANGES-1:0]  valid_vec;

   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        pend_ff, pend_in;
   logic                        hit_ff, hit_in;
   logic [srt_pkg::SHARD_W-1:0] shard_ff, shard_in;
   logic                        drop_ff, drop_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_hit_ff, rsp_hit_in;
   logic [srt_pkg::SHARD_W-1:0] rsp_shard_ff, rsp_shard_in;
   logic                        rsp_cover_ff, rsp_cover_in;
   logic                        rsp_ovl_ff, rsp_ovl_in;
   logic                        rsp_drop_ff, rsp_drop_in;
   logic [srt_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                        accept;
   logic                        shard_ok;
   logic                        any_eq;
   logic                        any_hit;
   logic [srt_pkg::SHARD_W-1:0] hit_shard;
   logic                        all_link;
   logic                        all_tail;
   logic                        any_ovl;
   logic                        load_rsp;

   assign req_bus.ready = !pend_ff;
   assign accept        = req_bus.valid && req_bus.ready;
   assign shard_ok      = int'(req_bus.shard_index) < MAX_SHARDS;

   always_comb begin
      cmd.clear           = accept && (req_bus.op == srt_pkg::OP_CLEAR);
      cmd.insert          = accept && (req_bus.op == srt_pkg::OP_INSERT) && shard_ok;
      cmd.any_eq          = any_eq;
      cmd.room            = int'(count_ff) < MAX_RANGES;
      cmd.key.first_slot  = req_bus.range_start;
      cmd.key.last_slot   = req_bus.range_end;
      cmd.key.shard       = req_bus.shard_index;
      cmd.query           = req_bus.query_slot;
   end

   for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
      srt_pkg::srt_range_type   left_range;
      logic                     left_valid;
      logic                     left_lt;
      logic [srt_pkg::SLOT_W:0] link_expect;
      logic                     right_valid;
      logic                     right_le;

      if (i == 0) begin : g_head
         assign left_range  = '0;
         assign left_valid  = 1'b0;
         assign left_lt     = 1'b1;
         assign link_expect = '0;
      end else begin : g_body
         assign left_range  = ranges[i-1];
         assign left_valid  = valid_vec[i-1];
         assign left_lt     = flags[i-1].lt;
         assign link_expect = end_plus[i-1];
      end

      if (i == MAX_RANGES - 1) begin : g_tail
         assign right_valid = 1'b0;
         assign right_le    = 1'b0;
      end else begin : g_mid
         assign right_valid = valid_vec[i+1];
         assign right_le    = flags[i+1].le;
      end

      srt_cell #(
         .NUM_SLOTS (NUM_SLOTS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_range  (left_range),
         .left_valid  (left_valid),
         .left_lt     (left_lt),
         .link_expect (link_expect),
         .right_valid (right_valid),
         .right_le    (right_le),
         .range_out   (ranges[i]),
         .valid_out   (valid_vec[i]),
         .flags       (flags[i]),
         .end_plus    (end_plus[i])
      );
   end

   always_comb begin
      any_eq    = 1'b0;
      any_hit   = 1'b0;
      hit_shard = '0;
      all_link  = 1'b1;
      all_tail  = 1'b1;
      any_ovl   = 1'b0;
      for (int i = 0; i < MAX_RANGES; i++) begin
         any_eq    = any_eq | flags[i].eq;
         any_hit   = any_hit | flags[i].hit;
         hit_shard = hit_shard | (flags[i].hit ? ranges[i].shard : '0);
         all_link  = all_link & flags[i].link_ok;
         all_tail  = all_tail & flags[i].tail_ok;
         any_ovl   = any_ovl | flags[i].overlap;
      end
   end

   assign load_rsp = pend_ff && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      count_in = count_ff;
      pend_in  = pend_ff;
      hit_in   = hit_ff;
      shard_in = shard_ff;
      drop_in  = drop_ff;
      if (load_rsp) begin
         pend_in = 1'b0;
      end
      if (accept) begin
         pend_in  = 1'b1;
         hit_in   = (req_bus.op == srt_pkg::OP_LOOKUP) && any_hit;
         shard_in = (req_bus.op == srt_pkg::OP_LOOKUP) ? hit_shard : '0;
         drop_in  = cmd.insert && !any_eq && !cmd.room;
         if (cmd.clear) begin
            count_in = '0;
         end else if (cmd.insert && !any_eq && cmd.room) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_shard_in = rsp_shard_ff;
      rsp_cover_in = rsp_cover_ff;
      rsp_ovl_in   = rsp_ovl_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_count_in = rsp_count_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit_ff;
         rsp_shard_in = shard_ff;
         rsp_cover_in = valid_vec[0] && all_link && all_tail;
         rsp_ovl_in   = any_ovl;
         rsp_drop_in  = drop_ff;
         rsp_count_in = srt_pkg::COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff       <= hit_in;
      shard_ff     <= shard_in;
      drop_ff      <= drop_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_shard_ff <= rsp_shard_in;
      rsp_cover_ff <= rsp_cover_in;
      rsp_ovl_ff   <= rsp_ovl_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.hit            = rsp_hit_ff;
   assign rsp_bus.found_shard    = rsp_shard_ff;
   assign rsp_bus.covers_all     = rsp_cover_ff;
   assign rsp_bus.overlap_seen   = rsp_ovl_ff;
   assign rsp_bus.insert_dropped = rsp_drop_ff;
   assign rsp_bus.entry_count    = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= MAX_RANGES)
      else $error("stored range count exceeds table size");

   a_valid_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("occupied cells disagree with stored count");

   a_hit_needs_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.hit |-> rsp_bus.entry_count != '0)
      else $error("hit reported on an empty table");

   a_cover_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.covers_all |-> !rsp_bus.overlap_seen)
      else $error("full coverage reported together with overlap");

endmodule

// ===== rtl/srt_cell.sv =====
// One table cell: holds a range, compares it against the item and shifts right on insert.
module srt_cell #(
   parameter int NUM_SLOTS = 16384
) (
   input  logic                          clock,
   input  logic                          reset,
   input  srt_pkg::srt_cmd_type          cmd,
   input  srt_pkg::srt_range_type        left_range,
   input  logic                          left_valid,
   input  logic                          left_lt,
   input  logic [srt_pkg::SLOT_W:0]      link_expect,
   input  logic                          right_valid,
   input  logic                          right_le,
   output srt_pkg::srt_range_type        range_out,
   output logic                          valid_out,
   output srt_pkg::srt_flags_type        flags,
   output logic [srt_pkg::SLOT_W:0]      end_plus
);

   srt_pkg::srt_range_type range_ff, range_in;
   logic                   valid_ff, valid_in;

   always_comb begin
      flags.lt      = valid_ff && (range_ff.first_slot < cmd.key.first_slot);
      flags.eq      = valid_ff && (range_ff.first_slot == cmd.key.first_slot);
      flags.le      = valid_ff && (range_ff.first_slot <= cmd.query);
      flags.hit     = flags.le && !right_le && (cmd.query <= range_ff.last_slot);
      flags.overlap = valid_ff && left_valid && (range_ff.first_slot <= left_range.last_slot);
      flags.link_ok = !valid_ff || ({1'b0, range_ff.first_slot} == link_expect);
      flags.tail_ok = !valid_ff || right_valid ||
                      ((32'(range_ff.last_slot) + 32'd1) == 32'(NUM_SLOTS));
   end

   assign end_plus  = {1'b0, range_ff.last_slot} + {{srt_pkg::SLOT_W{1'b0}}, 1'b1};
   assign range_out = range_ff;
   assign valid_out = valid_ff;

   always_comb begin
      range_in = range_ff;
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (cmd.insert) begin
         if (cmd.any_eq) begin
            // overwrite the range with the same start
            if (flags.eq) begin
               range_in.last_slot = cmd.key.last_slot;
               range_in.shard     = cmd.key.shard;
            end
         end else if (cmd.room && !flags.lt) begin
            if (left_lt) begin
               range_in = cmd.key;
               valid_in = 1'b1;
            end else begin
               // make room: take the left neighbor's range
               range_in = left_range;
               valid_in = left_valid;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      range_ff <= range_in;
   end

endmodule
